// File: rtl/core/fbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared constants, codes and types of the free block cache.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int DEPTH     = 32;
    localparam int ADDR_BITS = 32;
    localparam int SIZE_BITS = 24;

    // Entry count, wide enough to hold DEPTH itself.
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = ((ADDR_BITS + SIZE_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACT_HIT     = 3'd0,
        ACT_ALLOC   = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_STORED  = 3'd3,
        ACT_NONE    = 3'd4
    } action_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] max_pages;
        logic [5:0]           capacity;
    } cfg_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// File: rtl/core/free_block_cache_exact_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_cache_exact_match
// Cache of freed blocks with oldest-first exact-size reuse.
// ----------------------------------------------------------------------------
// The cached blocks sit in a row of cells, oldest in cell 0, that shift
// toward cell 0 one place per cycle while the row is shifting. A free, an
// oversized or empty-cache allocate and a release-all of an empty cache are
// answered from the idle state; an ignored kind gives no result. An allocate
// that searches passes every one of its n cached blocks once through the
// head cell in the scan state and then loads the result in the finish state.
// The first hit is dropped at the head cell and the others are written back
// at the tail, so order is kept. A release-all emits one block per cycle
// from the head cell while the result side does not stall. One transaction
// is worked on at a time, and a new input transaction is accepted only while
// the result register is empty or is being read in the same cycle.
module free_block_cache_exact_match (
    input  logic          aclk,
    input  logic          aresetn,
    // APB configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Input requests
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [fbc_pkg::DATA_W-1:0] s_tdata,  // block_pages, block_addr
    input  logic [1:0]    s_tuser,               // kind
    // Results
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [fbc_pkg::DATA_W-1:0] m_tdata,  // out_addr, out_pages
    output logic [2:0]    m_tuser,               // action
    output logic          m_tlast
);
    import fbc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DRAIN
    } state_t;

    cfg_t cfg;

    fbc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Cell row
    logic [ADDR_BITS-1:0] cell_addr  [DEPTH];
    logic [SIZE_BITS-1:0] cell_pages [DEPTH];
    cell_ctl_t            cell_ctl   [DEPTH];

    logic                 shift_en;
    logic                 ld_en;
    logic [CNT_W-1:0]     ld_pos;
    logic [ADDR_BITS-1:0] ld_addr;
    logic [SIZE_BITS-1:0] ld_pages;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ADDR_BITS-1:0] nbr_addr;
            logic [SIZE_BITS-1:0] nbr_pages;

            if (gi == DEPTH - 1) begin : g_tail
                assign nbr_addr  = '0;
                assign nbr_pages = '0;
            end else begin : g_mid
                assign nbr_addr  = cell_addr[gi+1];
                assign nbr_pages = cell_pages[gi+1];
            end

            assign cell_ctl[gi].shift = shift_en;
            assign cell_ctl[gi].load  = ld_en && (ld_pos == CNT_W'(gi));

            fbc_cell u_cell (
                .aclk      (aclk),
                .ctl       (cell_ctl[gi]),
                .nbr_addr  (nbr_addr),
                .nbr_pages (nbr_pages),
                .ld_addr   (ld_addr),
                .ld_pages  (ld_pages),
                .addr      (cell_addr[gi]),
                .pages     (cell_pages[gi])
            );
        end
    endgenerate

    // Control state
    state_t               state_reg,     state_next;
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic [SIZE_BITS-1:0] total_reg,     total_next;
    logic [CNT_W-1:0]     steps_reg,     steps_next;
    logic [SIZE_BITS-1:0] req_pages_reg, req_pages_next;
    logic                 found_reg,     found_next;
    logic [ADDR_BITS-1:0] hit_addr_reg,  hit_addr_next;
    logic                 m_valid_reg,   m_valid_next;
    action_t              m_action_reg,  m_action_next;
    logic [ADDR_BITS-1:0] m_addr_reg,    m_addr_next;
    logic [SIZE_BITS-1:0] m_pages_reg,   m_pages_next;
    logic                 m_last_reg,    m_last_next;

    logic [SIZE_BITS-1:0] in_pages;
    logic [ADDR_BITS-1:0] in_addr;
    logic [SIZE_BITS-1:0] quarter;
    logic [CNT_W-1:0]     cap_eff;
    logic [SIZE_BITS:0]   total_sum;
    logic                 out_free;
    logic                 free_reject;

    assign in_pages = s_tdata[SIZE_BITS-1:0];
    assign in_addr  = s_tdata[SIZE_BITS +: ADDR_BITS];
    assign quarter  = cfg.max_pages >> 2;
    assign cap_eff  = (CNT_W'(cfg.capacity) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                             : CNT_W'(cfg.capacity);
    assign total_sum = {1'b0, total_reg} + {1'b0, in_pages};
    assign free_reject = (in_pages > quarter) || (count_reg >= cap_eff) ||
                         (total_sum > {1'b0, cfg.max_pages});

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        steps_next     = steps_reg;
        req_pages_next = req_pages_reg;
        found_next     = found_reg;
        hit_addr_next  = hit_addr_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_action_next  = m_action_reg;
        m_addr_next    = m_addr_reg;
        m_pages_next   = m_pages_reg;
        m_last_next    = m_last_reg;
        shift_en       = 1'b0;
        ld_en          = 1'b0;
        ld_pos         = count_reg;
        ld_addr        = in_addr;
        ld_pages       = in_pages;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    unique case (s_tuser)
                        KIND_ALLOC: begin
                            if (in_pages <= quarter && count_reg != '0) begin
                                req_pages_next = in_pages;
                                steps_next     = count_reg;
                                found_next     = 1'b0;
                                state_next     = ST_SCAN;
                            end else begin
                                m_valid_next  = 1'b1;
                                m_action_next = ACT_ALLOC;
                                m_addr_next   = '0;
                                m_pages_next  = in_pages;
                                m_last_next   = 1'b1;
                            end
                        end
                        KIND_FREE: begin
                            m_valid_next = 1'b1;
                            m_addr_next  = in_addr;
                            m_pages_next = in_pages;
                            m_last_next  = 1'b1;
                            if (free_reject) begin
                                m_action_next = ACT_RELEASE;
                            end else begin
                                m_action_next = ACT_STORED;
                                ld_en         = 1'b1;
                                count_next    = count_reg + 1'b1;
                                total_next    = total_sum[SIZE_BITS-1:0];
                            end
                        end
                        KIND_RELEASE: begin
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_action_next = ACT_NONE;
                                m_addr_next   = '0;
                                m_pages_next  = '0;
                                m_last_next   = 1'b1;
                            end else begin
                                steps_next = count_reg;
                                state_next = ST_DRAIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // The head entry leaves the row; it is either the first exact
                // match and dropped, or written back at the new tail.
                shift_en   = 1'b1;
                steps_next = steps_reg - 1'b1;
                if (cell_pages[0] == req_pages_reg && !found_reg) begin
                    found_next    = 1'b1;
                    hit_addr_next = cell_addr[0];
                    count_next    = count_reg - 1'b1;
                    total_next    = total_reg - req_pages_reg;
                end else begin
                    ld_en    = 1'b1;
                    ld_pos   = count_reg - 1'b1;
                    ld_addr  = cell_addr[0];
                    ld_pages = cell_pages[0];
                end
                if (steps_reg == CNT_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = found_reg ? ACT_HIT : ACT_ALLOC;
                    m_addr_next   = found_reg ? hit_addr_reg : '0;
                    m_pages_next  = req_pages_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    shift_en      = 1'b1;
                    m_valid_next  = 1'b1;
                    m_action_next = ACT_RELEASE;
                    m_addr_next   = cell_addr[0];
                    m_pages_next  = cell_pages[0];
                    m_last_next   = (steps_reg == CNT_W'(1));
                    steps_next    = steps_reg - 1'b1;
                    if (steps_reg == CNT_W'(1)) begin
                        count_next = '0;
                        total_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            steps_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            steps_reg   <= steps_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        req_pages_reg <= req_pages_next;
        hit_addr_reg  <= hit_addr_next;
        m_action_reg  <= m_action_next;
        m_addr_reg    <= m_addr_next;
        m_pages_reg   <= m_pages_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({m_pages_reg, m_addr_reg});
    assign m_tuser  = m_action_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/core/fbc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_cell
// One entry of the block list: takes its younger neighbor on a shift, or a
// new block on a load.
// ----------------------------------------------------------------------------
module fbc_cell (
    input  logic                             aclk,
    input  fbc_pkg::cell_ctl_t               ctl,
    input  logic [fbc_pkg::ADDR_BITS-1:0]    nbr_addr,
    input  logic [fbc_pkg::SIZE_BITS-1:0]    nbr_pages,
    input  logic [fbc_pkg::ADDR_BITS-1:0]    ld_addr,
    input  logic [fbc_pkg::SIZE_BITS-1:0]    ld_pages,
    output logic [fbc_pkg::ADDR_BITS-1:0]    addr,
    output logic [fbc_pkg::SIZE_BITS-1:0]    pages
);
    import fbc_pkg::*;

    logic [ADDR_BITS-1:0] addr_reg;
    logic [SIZE_BITS-1:0] pages_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            addr_reg  <= ld_addr;
            pages_reg <= ld_pages;
        end else if (ctl.shift) begin
            addr_reg  <= nbr_addr;
            pages_reg <= nbr_pages;
        end
    end

    assign addr  = addr_reg;
    assign pages = pages_reg;

endmodule

// File: rtl/core/fbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_cfg
// Register port: page limit and block capacity.
// ----------------------------------------------------------------------------
module fbc_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output fbc_pkg::cfg_t cfg
);
    import fbc_pkg::*;

    localparam logic REG_MAX_PAGES = 1'b0;
    localparam logic REG_CAPACITY  = 1'b1;

    logic [SIZE_BITS-1:0] max_pages_reg;
    logic [5:0]           capacity_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pages_reg <= SIZE_BITS'(512);
            capacity_reg  <= 6'd32;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MAX_PAGES: max_pages_reg <= pwdata[SIZE_BITS-1:0];
                REG_CAPACITY:  capacity_reg  <= pwdata[5:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_PAGES: prdata = 32'(max_pages_reg);
            REG_CAPACITY:  prdata = 32'(capacity_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.max_pages = max_pages_reg;
    assign cfg.capacity  = capacity_reg;

endmodule

// File: dv/free_block_cache_exact_match_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_cache_exact_match_tb
// Self-checking testbench of the free block cache with exact-size reuse.
// ----------------------------------------------------------------------------
// A behavioral copy of the cache runs beside the block and predicts every
// result of each accepted request. A monitor compares each result
// transaction, field by field, with the oldest prediction. Directed tests
// cover the edge cases of sizes, capacity and page total. Random phases run
// under several register settings, with random gaps on both stream sides in all phases but one.
module free_block_cache_exact_match_tb;
    import fbc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    // Longest silent work of the block: a full search plus some margin.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam logic [2:0] REG_MAX_PAGES = 3'd0;
    localparam logic [2:0] REG_CAPACITY  = 3'd4;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    typedef struct {
        action_t              action;
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] pages;
        logic                 last;
    } cache_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    // Shadow copy of the cache.
    logic [ADDR_BITS-1:0] cached_addr [DEPTH];
    logic [SIZE_BITS-1:0] cached_pages [DEPTH];
    int                   cached_count;
    logic [SIZE_BITS-1:0] cached_total;
    logic [SIZE_BITS-1:0] cfg_max_pages;
    logic [5:0]           cfg_capacity;

    cache_result_t        expected_results [$];
    int                   errors;
    int                   cycle_count;
    bit                   no_idle;

    free_block_cache_exact_match i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 16);
    end

    task automatic push_result(action_t action, logic [ADDR_BITS-1:0] addr,
                               logic [SIZE_BITS-1:0] pages, logic last);
        cache_result_t r;
        r.action = action;
        r.addr   = addr;
        r.pages  = pages;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    // Updates the shadow cache for one accepted request and queues its results.
    task automatic predict_cache(logic [1:0] kind, logic [SIZE_BITS-1:0] pages,
                                 logic [ADDR_BITS-1:0] addr);
        int n;
        int hit;
        int eff_cap;
        n   = cached_count;
        hit = -1;
        eff_cap = (cfg_capacity < DEPTH) ? int'(cfg_capacity) : DEPTH;
        case (kind)
            KIND_ALLOC: begin
                if (pages <= cfg_max_pages / 4 && n > 0) begin
                    for (int i = 0; i < n; i++) begin
                        if (hit < 0 && cached_pages[i] == pages) hit = i;
                    end
                end
                if (hit >= 0) begin
                    push_result(ACT_HIT, cached_addr[hit], pages, 1'b1);
                    for (int j = hit; j + 1 < n; j++) begin
                        cached_addr[j]  = cached_addr[j+1];
                        cached_pages[j] = cached_pages[j+1];
                    end
                    cached_count = n - 1;
                    cached_total = cached_total - pages;
                end else begin
                    push_result(ACT_ALLOC, '0, pages, 1'b1);
                end
            end
            KIND_FREE: begin
                if (pages > cfg_max_pages / 4 || n + 1 > eff_cap ||
                    {1'b0, cached_total} + {1'b0, pages} > {1'b0, cfg_max_pages}) begin
                    push_result(ACT_RELEASE, addr, pages, 1'b1);
                end else begin
                    cached_addr[n]  = addr;
                    cached_pages[n] = pages;
                    cached_count    = n + 1;
                    cached_total    = cached_total + pages;
                    push_result(ACT_STORED, addr, pages, 1'b1);
                end
            end
            KIND_RELEASE: begin
                if (n == 0) begin
                    push_result(ACT_NONE, '0, '0, 1'b1);
                end
                for (int i = 0; i < n; i++) begin
                    push_result(ACT_RELEASE, cached_addr[i], cached_pages[i], i + 1 == n);
                end
                cached_count = 0;
                cached_total = '0;
            end
            default: begin
            end
        endcase
    endtask

    // Offers one request on the input stream and waits until it is taken.
    task automatic send_item(logic [1:0] kind, logic [SIZE_BITS-1:0] pages,
                             logic [ADDR_BITS-1:0] addr);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 16) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {addr, pages};
        do @(posedge aclk); while (!s_tready);
        predict_cache(kind, pages, addr);
    endtask

    // Lets all outstanding work finish, including requests with no result.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == REG_MAX_PAGES) cfg_max_pages = data[SIZE_BITS-1:0];
        else if (addr == REG_CAPACITY) cfg_capacity = data[5:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(logic [SIZE_BITS-1:0] max_pages, logic [5:0] capacity);
        wait_idle();
        apb_write(REG_MAX_PAGES, 32'(max_pages));
        apb_write(REG_CAPACITY, 32'(capacity));
    endtask

    // Reset settings: empty cache, oversized and zero-page blocks, kind three.
    task automatic test_reset_settings();
        send_item(KIND_RELEASE, 24'd0, 32'd0);
        send_item(KIND_ALLOC, 24'd5, 32'd0);
        send_item(KIND_FREE, 24'd128, 32'hFFFF_FFFF);
        send_item(KIND_FREE, 24'd129, 32'h0000_0000);
        send_item(KIND_FREE, 24'd0, 32'h1234_5678);
        send_item(KIND_UNUSED, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(KIND_ALLOC, 24'd129, 32'hFFFF_FFFF);
        send_item(KIND_ALLOC, 24'd0, 32'd0);
        send_item(KIND_ALLOC, 24'd7, 32'd0);
        send_item(KIND_FREE, 24'hFFFFFF, 32'hA5A5_5A5A);
        send_item(KIND_FREE, 24'd1, 32'h5A5A_A5A5);
        send_item(KIND_RELEASE, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(KIND_ALLOC, 24'd128, 32'd0);
    endtask

    // Full list, clamped capacity, page total limit and oldest-first matching.
    task automatic test_limits();
        set_config(24'd16, 6'd1);
        send_item(KIND_FREE, 24'd4, 32'h0000_0010);
        send_item(KIND_FREE, 24'd4, 32'h0000_0020);
        set_config(24'd16, 6'd63);
        send_item(KIND_FREE, 24'd4, 32'h0000_0030);
        send_item(KIND_FREE, 24'd4, 32'h0000_0040);
        send_item(KIND_FREE, 24'd4, 32'h0000_0050);
        send_item(KIND_FREE, 24'd1, 32'h0000_0060);
        send_item(KIND_ALLOC, 24'd4, 32'd0);
        send_item(KIND_RELEASE, 24'd0, 32'd0);
        set_config(24'd0, 6'd0);
        send_item(KIND_FREE, 24'd0, 32'h0000_0070);
        send_item(KIND_ALLOC, 24'd0, 32'd0);
        send_item(KIND_RELEASE, 24'd0, 32'd0);
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_pages();
        int r;
        r = $urandom_range(99);
        if (r < 10) return SIZE_BITS'($urandom());
        if (r < 20) return SIZE_BITS'($urandom_range(32'(cfg_max_pages) / 4));
        return SIZE_BITS'($urandom_range(8));
    endfunction

    task automatic run_random(int count);
        int sent;
        int r;
        logic [1:0] kind;
        logic [SIZE_BITS-1:0] pages;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            pages = pick_pages();
            if (r < 42) begin
                kind = KIND_FREE;
            end else if (r < 82) begin
                kind = KIND_ALLOC;
                // Aim most requests at a cached size so that hits and compaction occur.
                if (cached_count > 0 && $urandom_range(99) < 60) begin
                    pages = cached_pages[$urandom_range(cached_count - 1)];
                end
            end else if (r < 90) begin
                kind = KIND_RELEASE;
            end else begin
                kind = KIND_UNUSED;
            end
            send_item(kind, pages, $urandom());
            if (kind != KIND_UNUSED) sent++;
        end
    endtask

    task automatic test_random();
        logic [SIZE_BITS-1:0] max_list [6];
        logic [5:0]           cap_list [6];
        max_list = '{24'd512, 24'd64, 24'hFFFFFF, 24'd40, 24'd4, 24'd1000};
        cap_list = '{6'd32, 6'd4, 6'd63, 6'd33, 6'd2, 6'd0};
        for (int p = 0; p < 6; p++) begin
            set_config(max_list[p], cap_list[p]);
            no_idle = (p == 2);
            run_random(p == 5 ? 18 : 38);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin : check_results
        cache_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with none expected: action %0d addr %h pages %h",
                       m_tuser, m_tdata[31:0], m_tdata[55:32]);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser != want.action) begin
                    $error("action: expected %0d, actual %0d", want.action, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] != want.addr) begin
                    $error("out_addr: expected %h, actual %h", want.addr, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[55:32] != want.pages) begin
                    $error("out_pages: expected %h, actual %h", want.pages, m_tdata[55:32]);
                    errors++;
                end
                if (m_tlast != want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors        = 0;
        cycle_count   = 0;
        no_idle       = 1'b0;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        cached_count  = 0;
        cached_total  = '0;
        cfg_max_pages = 24'd512;
        cfg_capacity  = 6'd32;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_settings();
        test_limits();
        test_random();

        wait_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
